@@ design/mpe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpe_pkg
// Shared types, phase codes and Morse code tables for the phase encoder.
// ----------------------------------------------------------------------------
package mpe_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned LEN_W   = 3;
	localparam int unsigned PAT_W   = 6;

	localparam logic [PHASE_W-1:0] PH_DIT    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_DAH    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_SSPACE = 3'd2;
	localparam logic [PHASE_W-1:0] PH_LSPACE = 3'd3;
	localparam logic [PHASE_W-1:0] PH_WSPACE = 3'd4;

	// packed code: [7:5] element count (7 reads as 6), [5:0] pattern, 1 = dah
	localparam logic [7:0] LETTER_CODES [26] = '{
		8'h41, 8'h88, 8'h8A, 8'h64, 8'h20, 8'h82, 8'h66, 8'h80, 8'h40, 8'h87,
		8'h65, 8'h84, 8'h43, 8'h42, 8'h67, 8'h86, 8'h8D, 8'h62, 8'h60, 8'h21,
		8'h61, 8'h81, 8'h63, 8'h89, 8'h8B, 8'h8C
	};

	localparam logic [7:0] DIGIT_CODES [10] = '{
		8'hBF, 8'hAF, 8'hA7, 8'hA3, 8'hA1, 8'hA0, 8'hB0, 8'hB8, 8'hBC, 8'hBE
	};

	// ASCII space to slash
	localparam logic [7:0] PUNCT_A_CODES [16] = '{
		8'h00, 8'hEB, 8'hD2, 8'h00, 8'hC4, 8'h00, 8'hA8, 8'hDE,
		8'hB6, 8'hED, 8'h00, 8'hAA, 8'hF3, 8'hE1, 8'hD5, 8'hB2
	};

	// ASCII colon to at-sign
	localparam logic [7:0] PUNCT_B_CODES [7] = '{
		8'hF8, 8'hEA, 8'h00, 8'hB1, 8'h00, 8'hCC, 8'hDA
	};

	localparam logic [7:0] UNDERSCORE_CODE = 8'hCD;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [PAT_W-1:0] pat;
	} code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_WSPACE,
		ST_EMIT
	} state_t;

endpackage

@@ design/mpe_code_lut.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpe_code_lut
// Character to Morse code lookup; unencodable characters give length zero.
// ----------------------------------------------------------------------------
module mpe_code_lut (
	input  logic [mpe_pkg::CHAR_W-1:0] char_code,
	output mpe_pkg::code_t             code
);

	logic [7:0] raw;
	logic [7:0] off_upper;
	logic [7:0] off_lower;
	logic [7:0] off_digit;
	logic [7:0] off_punct_b;

	assign off_upper   = char_code - 8'd65;
	assign off_lower   = char_code - 8'd97;
	assign off_digit   = char_code - 8'd48;
	assign off_punct_b = char_code - 8'd58;

	always_comb begin
		priority if (char_code >= 8'd65 && char_code <= 8'd90) begin
			raw = mpe_pkg::LETTER_CODES[off_upper[4:0]];
		end else if (char_code >= 8'd97 && char_code <= 8'd122) begin
			raw = mpe_pkg::LETTER_CODES[off_lower[4:0]];
		end else if (char_code >= 8'd48 && char_code <= 8'd57) begin
			raw = mpe_pkg::DIGIT_CODES[off_digit[3:0]];
		end else if (char_code >= 8'd32 && char_code <= 8'd47) begin
			raw = mpe_pkg::PUNCT_A_CODES[char_code[3:0]];
		end else if (char_code >= 8'd58 && char_code <= 8'd64) begin
			raw = mpe_pkg::PUNCT_B_CODES[off_punct_b[2:0]];
		end else if (char_code == 8'd95) begin
			raw = mpe_pkg::UNDERSCORE_CODE;
		end else begin
			raw = 8'h00;
		end
	end

	// a count of seven is read as six; bit 5 stays part of the pattern
	assign code.len = (raw[7:5] == 3'd7) ? 3'd6 : raw[7:5];
	assign code.pat = raw[5:0];

endmodule

@@ design/mpe_emitter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpe_emitter
// Sequencer and pattern shifter: walks one code out as phases, one per beat.
// ----------------------------------------------------------------------------
module mpe_emitter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mpe_pkg::CHAR_W-1:0]   char_code,
	output logic [mpe_pkg::CHAR_W-1:0]   char_sel,
	input  mpe_pkg::code_t               code,
	input  logic                         cfg_wr_en,
	input  logic                         cfg_wr_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mpe_pkg::PHASE_W-1:0]  phase,
	output logic                         last_of_char
);

	mpe_pkg::state_t state_q, state_d;

	logic [mpe_pkg::CHAR_W-1:0]  char_q;
	logic [mpe_pkg::PAT_W-1:0]   pat_q;
	logic [mpe_pkg::LEN_W-1:0]   cnt_q;
	logic                        pend_ls_q;
	logic                        pend_ss_q;
	logic                        sym_q;
	logic                        lwm_q;
	logic                        out_valid_q;
	logic [mpe_pkg::PHASE_W-1:0] phase_q;
	logic                        last_q;

	logic                        slot_free;
	logic                        emit;
	logic [mpe_pkg::PHASE_W-1:0] emit_phase;
	logic                        emit_last;
	logic                        emit_elem;
	logic [mpe_pkg::LEN_W-1:0]   shamt;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == mpe_pkg::ST_IDLE);
	assign char_sel  = char_q;
	assign shamt     = 3'd6 - code.len;

	always_comb begin
		state_d    = state_q;
		emit       = 1'b0;
		emit_elem  = 1'b0;
		emit_phase = mpe_pkg::PH_DIT;
		emit_last  = 1'b0;
		unique case (state_q)
			mpe_pkg::ST_IDLE: begin
				if (in_valid) state_d = mpe_pkg::ST_LOAD;
			end
			mpe_pkg::ST_LOAD: begin
				state_d = (code.len == '0) ? mpe_pkg::ST_WSPACE : mpe_pkg::ST_EMIT;
			end
			mpe_pkg::ST_WSPACE: begin
				if (slot_free) begin
					emit       = 1'b1;
					emit_phase = mpe_pkg::PH_WSPACE;
					emit_last  = 1'b1;
					state_d    = mpe_pkg::ST_IDLE;
				end
			end
			mpe_pkg::ST_EMIT: begin
				if (slot_free) begin
					emit = 1'b1;
					priority if (pend_ls_q) begin
						emit_phase = mpe_pkg::PH_LSPACE;
					end else if (pend_ss_q) begin
						emit_phase = mpe_pkg::PH_SSPACE;
					end else begin
						emit_elem  = 1'b1;
						emit_phase = pat_q[mpe_pkg::PAT_W-1] ? mpe_pkg::PH_DAH
						                                    : mpe_pkg::PH_DIT;
						emit_last  = (cnt_q == 3'd1);
						if (cnt_q == 3'd1) state_d = mpe_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = mpe_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mpe_pkg::ST_IDLE;
			pend_ls_q   <= 1'b0;
			pend_ss_q   <= 1'b0;
			sym_q       <= 1'b0;
			lwm_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) sym_q <= cfg_wr_data;

			if (state_q == mpe_pkg::ST_LOAD) begin
				pend_ls_q <= lwm_q;
				pend_ss_q <= 1'b0;
			end else if (emit && state_q == mpe_pkg::ST_EMIT) begin
				if (pend_ls_q) begin
					pend_ls_q <= 1'b0;
				end else if (pend_ss_q) begin
					pend_ss_q <= 1'b0;
				end else begin
					pend_ss_q <= sym_q && (cnt_q != 3'd1);
				end
			end

			if (emit) begin
				if (state_q == mpe_pkg::ST_WSPACE) lwm_q <= 1'b0;
				else if (emit_last)                lwm_q <= 1'b1;
			end

			if (emit)           out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload and pattern shifter
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) char_q <= char_code;
		if (state_q == mpe_pkg::ST_LOAD) begin
			pat_q <= code.pat << shamt;
			cnt_q <= code.len;
		end else if (emit_elem) begin
			pat_q <= {pat_q[mpe_pkg::PAT_W-2:0], 1'b0};
			cnt_q <= cnt_q - 3'd1;
		end
		if (emit) begin
			phase_q <= emit_phase;
			last_q  <= emit_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign phase        = phase_q;
	assign last_of_char = last_q;

endmodule

@@ design/morse_phase_encoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_phase_encoder_core
// Turns ASCII characters into a stream of Morse dit/dah/space phases.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one char_code per beat. Output
//   channel out_valid/out_ready carries one phase per beat, last_of_char
//   marking the final phase of a character.
//   cfg_wr_en/cfg_wr_data set with_symbol_space; write only while idle.
//   A character is registered and looked up in the load state, then its
//   phases leave one per cycle, unless the receiver stalls, from a shifting
//   pattern register under a small sequencer. in_ready is high only when idle,
//   so a new character is taken only after the last phase of the previous one.
//   The first phase follows the character register and the load state.
//   When the receiver stalls the output register holds its beat and the
//   sequencer waits; nothing is dropped.
//   Reset clears the sequencer, the output valid, the symbol-space setting and
//   the previous-mark flag, so the first character gets no letter-space.
// ----------------------------------------------------------------------------
module morse_phase_encoder_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mpe_pkg::CHAR_W-1:0]   char_code,
	input  logic                         cfg_wr_en,
	input  logic                         cfg_wr_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mpe_pkg::PHASE_W-1:0]  phase,
	output logic                         last_of_char
);

	logic [mpe_pkg::CHAR_W-1:0] char_sel;
	mpe_pkg::code_t             code;

	mpe_code_lut u_lut (
		.char_code (char_sel),
		.code      (code)
	);

	mpe_emitter u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_code    (char_code),
		.char_sel     (char_sel),
		.code         (code),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.phase        (phase),
		.last_of_char (last_of_char)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a character was in flight");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> phase <= mpe_pkg::PH_WSPACE)
		else $error("phase code out of range");

	a_wspace_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == mpe_pkg::PH_WSPACE |-> last_of_char)
		else $error("word-space not flagged as last");

	a_spacer_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (phase == mpe_pkg::PH_LSPACE || phase == mpe_pkg::PH_SSPACE)
		|-> !last_of_char)
		else $error("spacer flagged as last");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for morse_phase_encoder_core: characters go in one per
// beat, each is turned into its expected phase beats by a local encoder model,
// and every output beat is checked in order against them. Both channels idle
// at random; the symbol-space setting is switched between runs of characters.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned RAND_CHARS   = 100;
	localparam int unsigned RAND_BLOCKS  = 4;
	localparam int unsigned TAIL_CYCLES  = 20;

	typedef struct packed {
		logic [mpe_pkg::PHASE_W-1:0] ph;
		logic                        last;
	} phase_beat_t;

	// packed Morse codes: [7:5] element count (7 means 6), low bits the pattern
	localparam logic [7:0] ALPHA_TAB [26] = '{
		8'h41, 8'h88, 8'h8A, 8'h64, 8'h20, 8'h82, 8'h66, 8'h80, 8'h40, 8'h87,
		8'h65, 8'h84, 8'h43, 8'h42, 8'h67, 8'h86, 8'h8D, 8'h62, 8'h60, 8'h21,
		8'h61, 8'h81, 8'h63, 8'h89, 8'h8B, 8'h8C
	};
	localparam logic [7:0] NUM_TAB [10] = '{
		8'hBF, 8'hAF, 8'hA7, 8'hA3, 8'hA1, 8'hA0, 8'hB0, 8'hB8, 8'hBC, 8'hBE
	};
	localparam logic [7:0] SYM_LO_TAB [16] = '{
		8'h00, 8'hEB, 8'hD2, 8'h00, 8'hC4, 8'h00, 8'hA8, 8'hDE,
		8'hB6, 8'hED, 8'h00, 8'hAA, 8'hF3, 8'hE1, 8'hD5, 8'hB2
	};
	localparam logic [7:0] SYM_HI_TAB [7] = '{
		8'hF8, 8'hEA, 8'h00, 8'hB1, 8'h00, 8'hCC, 8'hDA
	};
	localparam logic [7:0] LOWLINE_CODE = 8'hCD;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [mpe_pkg::CHAR_W-1:0]  char_code = '0;
	logic                        cfg_wr_en = 1'b0;
	logic                        cfg_wr_data = 1'b0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [mpe_pkg::PHASE_W-1:0] phase;
	logic                        last_of_char;

	morse_phase_encoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_code    (char_code),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.phase        (phase),
		.last_of_char (last_of_char)
	);

	logic [mpe_pkg::CHAR_W-1:0] char_backlog [$];
	logic [mpe_pkg::CHAR_W-1:0] encodable [$];
	phase_beat_t                expected_phases [$];

	logic        sym_space_on = 1'b0;
	logic        after_mark = 1'b0;
	logic        in_beat = 1'b0;
	logic        out_beat = 1'b0;
	int unsigned send_gap = 0;
	int unsigned send_calm = 0;
	int unsigned recv_stall = 0;
	int unsigned recv_calm = 0;
	int unsigned cycle_count = 0;
	int unsigned chars_sent = 0;
	int unsigned phases_checked = 0;
	int unsigned drain_pauses = 0;
	int unsigned fail_count = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] morse_code_of(input logic [7:0] c);
		if (c >= 8'd65 && c <= 8'd90) return ALPHA_TAB[c - 8'd65];
		if (c >= 8'd97 && c <= 8'd122) return ALPHA_TAB[c - 8'd97];
		if (c >= 8'd48 && c <= 8'd57) return NUM_TAB[c - 8'd48];
		if (c >= 8'd32 && c <= 8'd47) return SYM_LO_TAB[c - 8'd32];
		if (c >= 8'd58 && c <= 8'd64) return SYM_HI_TAB[c - 8'd58];
		if (c == 8'd95) return LOWLINE_CODE;
		return 8'h00;
	endfunction

	function automatic void queue_phase(input logic [mpe_pkg::PHASE_W-1:0] ph,
		input logic last);
		expected_phases.push_back(phase_beat_t'{ph, last});
	endfunction

	function automatic void predict_phases(input logic [7:0] c);
		logic [7:0]  code;
		int unsigned len;
		code = morse_code_of(c);
		len = code[7:5];
		if (len == 7) len = 6;
		if (len == 0) begin
			queue_phase(mpe_pkg::PH_WSPACE, 1'b1);
			after_mark = 1'b0;
			return;
		end
		if (after_mark) queue_phase(mpe_pkg::PH_LSPACE, 1'b0);
		for (int i = 0; i < len; i++) begin
			if (i > 0 && sym_space_on) queue_phase(mpe_pkg::PH_SSPACE, 1'b0);
			queue_phase(code[len - 1 - i] ? mpe_pkg::PH_DAH : mpe_pkg::PH_DIT,
				(i + 1 == len));
		end
		after_mark = 1'b1;
	endfunction

	function automatic logic [7:0] pick_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 62) return encodable[$urandom_range(0, encodable.size() - 1)];
		if (r < 74) return 8'h20;
		return 8'($urandom_range(0, 255));
	endfunction

	// sampling side: checks output beats, predicts on input beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_beat <= 1'b0;
			out_beat <= 1'b0;
		end else begin
			in_beat <= in_valid && in_ready;
			out_beat <= out_valid && out_ready;
			if (out_valid && out_ready) begin
				if (expected_phases.size() == 0) begin
					$error("unexpected beat: phase %0d last_of_char %0d", phase, last_of_char);
					fail_count++;
				end else begin
					phase_beat_t exp_beat;
					exp_beat = expected_phases.pop_front();
					phases_checked++;
					if (phase !== exp_beat.ph) begin
						$error("phase mismatch: expected %0d, got %0d", exp_beat.ph, phase);
						fail_count++;
					end
					if (last_of_char !== exp_beat.last) begin
						$error("last_of_char mismatch: expected %0d, got %0d",
							exp_beat.last, last_of_char);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_phases(char_code);
				chars_sent++;
			end
		end
	end

	// character driver
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_beat)) begin
			if (in_beat) begin
				if (send_calm > 0) begin
					send_calm--;
					send_gap = 0;
				end else begin
					send_gap = $urandom_range(0, 18);
					if ($urandom_range(0, 29) == 0) send_calm = $urandom_range(15, 40);
				end
			end
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (char_backlog.size() > 0) begin
				char_code <= char_backlog.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_beat) begin
				if (recv_calm > 0) begin
					recv_calm--;
					recv_stall = 0;
				end else begin
					recv_stall = $urandom_range(0, 18);
					if ($urandom_range(0, 29) == 0) recv_calm = $urandom_range(20, 60);
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// wait for every beat to drain, then for the sequencer to return idle;
	// checked at the rising edge, where the driver's valid and backlog are settled
	task automatic settle_idle();
		while (!(char_backlog.size() == 0 && !in_valid && expected_phases.size() == 0))
			@(posedge clk);
		repeat (4) @(negedge clk);
		drain_pauses++;
	endtask

	task automatic write_sym_space(input logic on);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= on;
		sym_space_on = on;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int unsigned pause_at;
		for (int c = 0; c < 256; c++)
			if (morse_code_of(8'(c)) != 8'h00) encodable.push_back(8'(c));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// symbol-space off from reset: first char has no letter-space, word-space after a mark,
		// dollar sign, unencodable controls and top-bit bytes
		char_backlog = '{8'h45, 8'h24, 8'h30, 8'h20, 8'hFF, 8'h54, 8'h00, 8'h23,
			8'h61, 8'h5A, 8'h5F, 8'h80, 8'h7F, 8'h2E};
		settle_idle();

		write_sym_space(1'b1);
		char_backlog = '{8'h24, 8'h29, 8'h78, 8'h39, 8'h20, 8'h40, 8'h51};
		settle_idle();

		for (int b = 0; b < RAND_BLOCKS; b++) begin
			write_sym_space(b[0]);
			pause_at = $urandom_range(20, 80);
			for (int n = 0; n < RAND_CHARS; n++) begin
				if (n == pause_at) settle_idle();
				char_backlog.push_back(pick_char());
			end
			settle_idle();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_phases.size() != 0) begin
			$error("%0d expected phases never arrived", expected_phases.size());
			fail_count++;
		end

		$display("Sent %0d characters, checked %0d phase beats, %0d errors.",
			chars_sent, phases_checked, fail_count);
		$display("Symbol spacing toggled on and off, %0d full drains with random stalls.",
			drain_pauses);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/mpe_pkg.sv
design/mpe_code_lut.sv
design/mpe_emitter.sv
design/morse_phase_encoder_core.sv
tb/tb.sv
